[design/cbp_pkg.sv]
// Shared constants, request and register codes, and interface structs for the conv point unit.
`timescale 1ns / 1ps
`default_nettype none

package cbp_pkg;

  // Kernel geometry
  localparam int KERNEL_SIZE = 3;
  localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PAD         = KERNEL_SIZE / 2;

  // Default store sizes
  localparam int ACT_DEPTH_DEF    = 16384;
  localparam int WEIGHT_DEPTH_DEF = 65536;
  localparam int MAX_CHANNELS_DEF = 64;

  // Datapath widths
  localparam int ACT_IDX_W  = 20;  // flat activation index before range check
  localparam int WGT_IDX_W  = 17;  // flat weight index before range check
  localparam int ACC_W      = 43;  // up to 127*9 products of 32 bits
  localparam int ACC_LO_W   = 22;  // low part of the split scale multiply
  localparam int SUM_W      = 60;  // acc * scale plus rounding
  localparam int FRAC_SHIFT = 24;
  localparam int RES_W      = SUM_W - FRAC_SHIFT + 1;

  // Pipeline depth from tap issue to accumulator update
  localparam int DRAIN_CYCLES = 3;

  // Request codes
  localparam logic [2:0] REQ_LOAD_ACT   = 3'd0;
  localparam logic [2:0] REQ_LOAD_WGT   = 3'd1;
  localparam logic [2:0] REQ_LOAD_SCALE = 3'd2;
  localparam logic [2:0] REQ_LOAD_BIAS  = 3'd3;
  localparam logic [2:0] REQ_COMPUTE    = 3'd4;

  // Configuration register indexes
  localparam int CFG_DATA_W = 7;
  localparam logic [2:0] CFG_IN_CH   = 3'd0;
  localparam logic [2:0] CFG_OUT_CH  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_STRIDE  = 3'd4;

  // Configuration reset values
  localparam logic [6:0] IN_CH_RST   = 7'd16;
  localparam logic [6:0] OUT_CH_RST  = 7'd16;
  localparam logic [5:0] HEIGHT_RST  = 6'd32;
  localparam logic [5:0] WIDTH_RST   = 6'd32;
  localparam logic [1:0] STRIDE_RST  = 2'd1;

  typedef struct packed {
    logic [6:0] in_channel_count;
    logic [6:0] out_channel_count;
    logic [5:0] in_height;
    logic [5:0] in_width;
    logic [1:0] conv_stride;
  } cbp_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_act;
    logic load_wgt;
    logic load_scale;
    logic load_bias;
    logic capture;
    logic setup;
    logic start_taps;
    logic tap;
    logic mul;
    logic sum;
    logic emit_ok;
    logic emit_bad;
  } cbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_bad;
    logic no_taps;
    logic last_tap;
  } cbp_stat_t;

endpackage

`default_nettype wire

[design/cbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/cbp_ctrl.sv]
// Controller state machine: request decode, tap sequencing, drain and result steps.
`timescale 1ns / 1ps
`default_nettype none

module cbp_ctrl import cbp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic [2:0] req_type,
  input  wire cbp_stat_t stat,
  output logic           busy,
  output cbp_cmd_t       cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_BASE  = 8'b0000_0100,
    ST_RUN   = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_SUM   = 8'b0100_0000,
    ST_FINAL = 8'b1000_0000
  } cbp_state_t;

  localparam logic [1:0] DRAIN_LAST = 2'(DRAIN_CYCLES - 1);

  cbp_state_t state_r, state_nxt;
  logic [1:0] drain_cnt_r, drain_cnt_nxt;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    drain_cnt_nxt = drain_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_LOAD_ACT:   cmd.load_act   = 1'b1;
            REQ_LOAD_WGT:   cmd.load_wgt   = 1'b1;
            REQ_LOAD_SCALE: cmd.load_scale = 1'b1;
            REQ_LOAD_BIAS:  cmd.load_bias  = 1'b1;
            REQ_COMPUTE: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        cmd.setup = 1'b1;
        if (stat.pos_bad) begin
          cmd.emit_bad = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.start_taps = 1'b1;
        drain_cnt_nxt  = '0;
        state_nxt      = stat.no_taps ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        cmd.tap = 1'b1;
        if (stat.last_tap) begin
          drain_cnt_nxt = '0;
          state_nxt     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt_r == DRAIN_LAST) begin
          state_nxt = ST_MUL;
        end else begin
          drain_cnt_nxt = drain_cnt_r + 2'd1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.emit_ok = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

[design/cbp_datapath.sv]
// Datapath: stores, tap address generation, MAC pipeline, scale, bias and saturation.
`timescale 1ns / 1ps
`default_nettype none

module cbp_datapath import cbp_pkg::*; #(
  parameter int ACT_DEPTH    = ACT_DEPTH_DEF,
  parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cbp_cmd_t    cmd,
  input  wire cbp_cfg_t    cfg,
  input  wire logic [15:0] in_load_address,
  input  wire logic [15:0] in_load_value,
  input  wire logic [5:0]  in_out_channel,
  input  wire logic [4:0]  in_out_row,
  input  wire logic [4:0]  in_out_col,
  output cbp_stat_t        stat,
  output logic             out_valid,
  output logic [15:0]      out_conv_value,
  output logic             out_status
);

  localparam int ACT_AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam logic [16:0] ACT_LIMIT_LD = 17'(ACT_DEPTH);
  localparam logic [16:0] WGT_LIMIT_LD = 17'(WEIGHT_DEPTH);
  localparam logic [16:0] CH_LIMIT_LD  = 17'(MAX_CHANNELS);
  localparam logic [8:0]  CH_LIMIT     = 9'(MAX_CHANNELS);
  localparam logic [ACT_IDX_W-1:0] ACT_LIMIT = ACT_IDX_W'(ACT_DEPTH);
  localparam logic [WGT_IDX_W-1:0] WGT_LIMIT = WGT_IDX_W'(WEIGHT_DEPTH);
  localparam logic [1:0]  K_LAST = 2'(KERNEL_SIZE - 1);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(32768);

  // Stride times a 5-bit coordinate, stride 1..3
  function automatic logic [6:0] times_stride(input logic [4:0] v, input logic [1:0] s);
    times_stride = ({2'b00, v} & {7{s[0]}}) + ({1'b0, v, 1'b0} & {7{s[1]}});
  endfunction

  // ---------------------------------------------------------------------------
  // Load beats: write enables with address range check
  logic [16:0] ld_addr;
  logic        act_we, wgt_we, scale_we, bias_we;

  assign ld_addr  = {1'b0, in_load_address};
  assign act_we   = cmd.load_act   && (ld_addr < ACT_LIMIT_LD);
  assign wgt_we   = cmd.load_wgt   && (ld_addr < WGT_LIMIT_LD);
  assign scale_we = cmd.load_scale && (ld_addr < CH_LIMIT_LD);
  assign bias_we  = cmd.load_bias  && (ld_addr < CH_LIMIT_LD);

  // ---------------------------------------------------------------------------
  // Captured compute request
  logic [5:0] oc_r;
  logic [4:0] row_r, col_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      oc_r  <= in_out_channel;
      row_r <= in_out_row;
      col_r <= in_out_col;
    end
  end

  // Position check, no division: row < H/s  <=>  row*s + s <= H
  logic [1:0] stride_eff;
  logic [6:0] row_s, col_s;
  logic       row_fits, col_fits, chan_fits;

  assign stride_eff = (cfg.conv_stride == 2'd0) ? 2'd1 : cfg.conv_stride;
  assign row_s      = times_stride(row_r, stride_eff);
  assign col_s      = times_stride(col_r, stride_eff);
  assign row_fits   = ({1'b0, row_s} + {6'b0, stride_eff}) <= {2'b00, cfg.in_height};
  assign col_fits   = ({1'b0, col_s} + {6'b0, stride_eff}) <= {2'b00, cfg.in_width};
  assign chan_fits  = ({1'b0, oc_r} < cfg.out_channel_count) && ({3'b000, oc_r} < CH_LIMIT);

  assign stat.pos_bad = !(row_fits && col_fits && chan_fits);
  assign stat.no_taps = (cfg.in_channel_count == 7'd0);

  // Per-request bases
  logic [12:0]       oc_ic_r;
  logic [11:0]       hw_r;
  logic signed [8:0] row0_r, col0_r;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      oc_ic_r <= {7'b0, oc_r} * {6'b0, cfg.in_channel_count};
      hw_r    <= {6'b0, cfg.in_height} * {6'b0, cfg.in_width};
      row0_r  <= $signed({2'b00, row_s}) - $signed(9'(PAD));
      col0_r  <= $signed({2'b00, col_s}) - $signed(9'(PAD));
    end
  end

  // ---------------------------------------------------------------------------
  // Tap counters: ic outer, kh, kw inner; weight index runs linearly
  logic [6:0]           ic_r;
  logic [1:0]           kh_r, kw_r;
  logic [ACT_IDX_W-1:0] chan_base_r;
  logic [WGT_IDX_W-1:0] wi_r;
  logic                 kw_last, kh_last;

  assign kw_last       = (kw_r == K_LAST);
  assign kh_last       = (kh_r == K_LAST);
  assign stat.last_tap = kw_last && kh_last && ((ic_r + 7'd1) == cfg.in_channel_count);

  always_ff @(posedge clk) begin
    if (cmd.start_taps) begin
      ic_r        <= '0;
      kh_r        <= '0;
      kw_r        <= '0;
      chan_base_r <= '0;
      wi_r        <= WGT_IDX_W'(oc_ic_r) * WGT_IDX_W'(KERNEL_TAPS);
    end else if (cmd.tap) begin
      wi_r <= wi_r + WGT_IDX_W'(1);
      if (kw_last) begin
        kw_r <= '0;
        if (kh_last) begin
          kh_r        <= '0;
          ic_r        <= ic_r + 7'd1;
          chan_base_r <= chan_base_r + {{(ACT_IDX_W - 12){1'b0}}, hw_r};
        end else begin
          kh_r <= kh_r + 2'd1;
        end
      end else begin
        kw_r <= kw_r + 2'd1;
      end
    end
  end

  // Tap address and padding check
  logic signed [8:0]    ih, iw;
  logic                 ih_in, iw_in, tap_ok;
  logic [ACT_IDX_W-1:0] ai;

  assign ih    = row0_r + $signed({7'b0, kh_r});
  assign iw    = col0_r + $signed({7'b0, kw_r});
  assign ih_in = !ih[8] && (ih[7:0] < {2'b00, cfg.in_height});
  assign iw_in = !iw[8] && (iw[7:0] < {2'b00, cfg.in_width});
  assign ai    = chan_base_r
               + ({{(ACT_IDX_W - 8){1'b0}}, ih[7:0]} * {{(ACT_IDX_W - 6){1'b0}}, cfg.in_width})
               + {{(ACT_IDX_W - 8){1'b0}}, iw[7:0]};
  assign tap_ok = ih_in && iw_in && (ai < ACT_LIMIT) && (wi_r < WGT_LIMIT);

  // ---------------------------------------------------------------------------
  // MAC pipeline: address, RAM read, product, accumulate
  logic              s1_ok_r, s2_ok_r, s3_ok_r;
  logic [ACT_AW-1:0] s1_ai_r;
  logic [WGT_AW-1:0] s1_wi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ok_r <= 1'b0;
      s2_ok_r <= 1'b0;
      s3_ok_r <= 1'b0;
    end else begin
      s1_ok_r <= cmd.tap && tap_ok;
      s2_ok_r <= s1_ok_r;
      s3_ok_r <= s2_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ai_r <= ACT_AW'(ai);
    s1_wi_r <= WGT_AW'(wi_r);
  end

  logic [15:0] act_q, wgt_q, scale_q, bias_q;

  cbp_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (ACT_AW'(in_load_address)),
    .wdata (in_load_value),
    .raddr (s1_ai_r),
    .rdata (act_q)
  );

  cbp_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (WGT_AW'(in_load_address)),
    .wdata (in_load_value),
    .raddr (s1_wi_r),
    .rdata (wgt_q)
  );

  cbp_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_scale_ram (
    .clk   (clk),
    .we    (scale_we),
    .waddr (CH_AW'(in_load_address)),
    .wdata (in_load_value),
    .raddr (CH_AW'(oc_r)),
    .rdata (scale_q)
  );

  cbp_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (CH_AW'(in_load_address)),
    .wdata (in_load_value),
    .raddr (CH_AW'(oc_r)),
    .rdata (bias_q)
  );

  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed(act_q) * $signed(wgt_q);
    if (cmd.start_taps) begin
      acc_r <= '0;
    end else if (s3_ok_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Scale: acc split in two partial products, then recombined with rounding
  logic signed [ACC_LO_W+16:0]       plo_r;
  logic signed [ACC_W-ACC_LO_W+15:0] phi_r;
  logic signed [SUM_W-1:0]           sum_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      plo_r <= $signed({1'b0, acc_r[ACC_LO_W-1:0]}) * $signed(scale_q);
      phi_r <= $signed(acc_r[ACC_W-1:ACC_LO_W]) * $signed(scale_q);
    end
    if (cmd.sum) begin
      sum_r <= (SUM_W'(phi_r) <<< ACC_LO_W) + SUM_W'(plo_r) + ROUND_HALF;
    end
  end

  // Shift back, add bias, saturate
  logic signed [SUM_W-1:0] sum_sh;
  logic signed [RES_W-1:0] res;
  logic [15:0]             sat;

  assign sum_sh = sum_r >>> FRAC_SHIFT;
  assign res    = $signed(sum_sh[RES_W-1:0]) + RES_W'($signed(bias_q));

  always_comb begin
    if (res > SAT_MAX) begin
      sat = 16'h7FFF;
    end else if (res < SAT_MIN) begin
      sat = 16'h8000;
    end else begin
      sat = res[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat
  logic        out_valid_r;
  logic [15:0] out_value_r;
  logic        out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ok || cmd.emit_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ok || cmd.emit_bad) begin
      out_value_r  <= cmd.emit_bad ? 16'h0000 : sat;
      out_status_r <= cmd.emit_bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_conv_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

[design/conv3x3_batchnorm_point_unit.sv]
// Top level: configuration registers, controller and datapath, port assertions.
// Compute runs the check, base, tap, drain, multiply, sum and final states; the tap
// loop does one multiply-accumulate per cycle through the activation and weight RAM
// read ports. A bad position's result beat is registered from the check state. Load
// beats leave busy low. busy drops in the result cycle, so the next request may be
// taken while the result is on the ports. Synchronous reset restores the
// configuration defaults; stores hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_batchnorm_point_unit import cbp_pkg::*; #(
  parameter int ACT_DEPTH    = ACT_DEPTH_DEF,
  parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_req_type,
  input  wire logic [15:0]           in_load_address,
  input  wire logic [15:0]           in_load_value,
  input  wire logic [5:0]            in_out_channel,
  input  wire logic [4:0]            in_out_row,
  input  wire logic [4:0]            in_out_col,
  output logic                       out_valid,
  output logic [15:0]                out_conv_value,
  output logic                       out_status,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  cbp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_channel_count  <= IN_CH_RST;
      cfg_r.out_channel_count <= OUT_CH_RST;
      cfg_r.in_height         <= HEIGHT_RST;
      cfg_r.in_width          <= WIDTH_RST;
      cfg_r.conv_stride       <= STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_CH:  cfg_r.in_channel_count  <= cfg_data;
        CFG_OUT_CH: cfg_r.out_channel_count <= cfg_data;
        CFG_HEIGHT: cfg_r.in_height         <= cfg_data[5:0];
        CFG_WIDTH:  cfg_r.in_width          <= cfg_data[5:0];
        CFG_STRIDE: cfg_r.conv_stride       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  cbp_cmd_t  cmd;
  cbp_stat_t stat;

  cbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  cbp_datapath #(
    .ACT_DEPTH    (ACT_DEPTH),
    .WEIGHT_DEPTH (WEIGHT_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .in_load_address (in_load_address),
    .in_load_value   (in_load_value),
    .in_out_channel  (in_out_channel),
    .in_out_row      (in_out_row),
    .in_out_col      (in_out_col),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_conv_value  (out_conv_value),
    .out_status      (out_status)
  );

  // A result beat only follows a cycle of compute work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a compute in progress");

  // An error result carries a zero value
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_conv_value == 16'h0000))
    else $error("error result with nonzero value");

  // A compute request always occupies the block in the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_COMPUTE)) |=> busy)
    else $error("compute request did not start");

  // A load or ignored request leaves the block free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type != REQ_COMPUTE)) |=> (!busy && !out_valid))
    else $error("load beat made the block busy or produced a result");

endmodule

`default_nettype wire
